[hdl/zsif_pkg.sv]
`timescale 1ns / 1ps

package zsif_pkg;

   // Sizes of the stores and of the register fields
   localparam int MAX_TAPS   = 64;
   localparam int MAX_INTERP = 8;

   localparam int TAP_IDX_W  = $clog2(MAX_TAPS);
   localparam int TAP_CNT_W  = $clog2(MAX_TAPS + 1);
   localparam int K_W        = (MAX_INTERP > 1) ? $clog2(MAX_INTERP) : 1;

   localparam int INTERP_W   = 4;
   localparam int SAMPLE_W   = 16;
   localparam int COEFF_W    = 18;
   localparam int TIME_W     = 32;
   localparam int COEFF_IDX_W = 6;

   // Arithmetic: Q3.14 coefficient times integer sample
   localparam int FRAC_BITS  = 14;
   localparam int PROD_W     = SAMPLE_W + COEFF_W;
   localparam int ACC_W      = PROD_W + TAP_IDX_W;
   localparam int Y_W        = ACC_W - FRAC_BITS;

   localparam logic signed [ACC_W-1:0]    ROUND_BIAS = ACC_W'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [SAMPLE_W-1:0] OUT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] OUT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;
   localparam logic [CSR_IDX_W-1:0] REG_INTERP_FACTOR = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_TAP_COUNT     = CSR_IDX_W'(1);

   // Request commands
   localparam logic CMD_FILTER = 1'b0;
   localparam logic CMD_LOAD   = 1'b1;

   // Controller to datapath
   typedef struct packed {
      logic                 capture;     // latch sample and timestamp
      logic                 coeff_we;    // coefficient load request
      logic                 hist_we;     // history write
      logic                 stuff_zero;  // history write carries a stuffed zero
      logic [TAP_IDX_W-1:0] hist_waddr;
      logic                 rd_issue;    // one tap read
      logic [TAP_IDX_W-1:0] rd_tap;
      logic [TAP_IDX_W-1:0] hist_raddr;
      logic                 acc_clear;
      logic                 emit;        // load the output register
      logic                 emit_last;
   } zsif_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic pipe_busy;
      logic out_free;
   } zsif_sts_type;

endpackage

[hdl/zsif_if.sv]
`timescale 1ns / 1ps

// Request channel
interface zsif_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   command;
   logic signed [zsif_pkg::SAMPLE_W-1:0]   sample;
   logic [zsif_pkg::TIME_W-1:0]            sample_time;
   logic [zsif_pkg::COEFF_IDX_W-1:0]       coeff_index;
   logic signed [zsif_pkg::COEFF_W-1:0]    coeff_value;

   modport source (output valid, command, sample, sample_time, coeff_index, coeff_value,
                   input ready);
   modport sink   (input valid, command, sample, sample_time, coeff_index, coeff_value,
                   output ready);
endinterface

// Result channel
interface zsif_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [zsif_pkg::SAMPLE_W-1:0]   filtered;
   logic [zsif_pkg::TIME_W-1:0]            out_time;
   logic                                   last;
   logic                                   saturated;

   modport source (output valid, filtered, out_time, last, saturated, input ready);
   modport sink   (input valid, filtered, out_time, last, saturated, output ready);
endinterface

// Register write channel
interface zsif_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [zsif_pkg::CSR_IDX_W-1:0]         index;
   logic [zsif_pkg::CSR_DATA_W-1:0]        data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[hdl/zero_stuff_interpolating_fir_unit.sv]
`timescale 1ns / 1ps

// Zero-stuffing interpolating FIR. A filter request (command 0) writes its
// sample into a 64-entry circular history followed by interp_factor-1 zeros
// and returns one result per write, each tagged with the request's timestamp,
// with last set on the final one. A load request (command 1) writes one Q3.14
// coefficient and returns nothing. Each result takes one history write, one
// multiply-accumulate per tap through the single read port of the history and
// coefficient memories, a drain of the multiply and add stages and a load of
// the output register, which waits until the previous result has been taken.
// Results are rounded half up to integer and saturated to 16 bits, with
// saturated flagging a clip. Both memories read as zero after reset with no
// clearing pass. Register writes (0: interp_factor, 1: tap_count, values
// clamped into range) are taken in any cycle and belong between requests.
module zero_stuff_interpolating_fir_unit (
   input  logic        clock,
   input  logic        reset,
   zsif_req_if.sink    req_if,
   zsif_rsp_if.source  rsp_if,
   zsif_csr_if.sink    csr_if
);

   zsif_pkg::zsif_cmd_type cmd;
   zsif_pkg::zsif_sts_type sts;

   logic                                  req_ready;
   logic                                  csr_ready;
   logic                                  rsp_valid;
   logic signed [zsif_pkg::SAMPLE_W-1:0]  rsp_filtered;
   logic [zsif_pkg::TIME_W-1:0]           rsp_out_time;
   logic                                  rsp_last;
   logic                                  rsp_saturated;

   zsif_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_command (req_if.command),
      .req_ready   (req_ready),
      .csr_valid   (csr_if.valid),
      .csr_index   (csr_if.index),
      .csr_data    (csr_if.data),
      .csr_ready   (csr_ready),
      .cmd         (cmd),
      .sts         (sts)
   );

   zsif_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_sample      (req_if.sample),
      .req_sample_time (req_if.sample_time),
      .req_coeff_index (req_if.coeff_index),
      .req_coeff_value (req_if.coeff_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_filtered    (rsp_filtered),
      .rsp_out_time    (rsp_out_time),
      .rsp_last        (rsp_last),
      .rsp_saturated   (rsp_saturated)
   );

   assign req_if.ready     = req_ready;
   assign csr_if.ready     = csr_ready;
   assign rsp_if.valid     = rsp_valid;
   assign rsp_if.filtered  = rsp_filtered;
   assign rsp_if.out_time  = rsp_out_time;
   assign rsp_if.last      = rsp_last;
   assign rsp_if.saturated = rsp_saturated;

endmodule

[hdl/zsif_ram.sv]
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port, registered read
module zsif_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

[hdl/zsif_ctrl.sv]
`timescale 1ns / 1ps

// Sequencer: registers, write pointer, output and tap counters
module zsif_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_command,
   output logic                               req_ready,
   input  logic                               csr_valid,
   input  logic [zsif_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [zsif_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic                               csr_ready,
   output zsif_pkg::zsif_cmd_type             cmd,
   input  zsif_pkg::zsif_sts_type             sts
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_WRITE = 2'd1;
   localparam logic [1:0] ST_MAC   = 2'd2;
   localparam logic [1:0] ST_DRAIN = 2'd3;

   logic [1:0]                         state_ff, state_in;
   logic [zsif_pkg::INTERP_W-1:0]      factor_ff, factor_in;
   logic [zsif_pkg::TAP_CNT_W-1:0]     taps_ff, taps_in;
   logic [zsif_pkg::TAP_IDX_W-1:0]     wp_ff, wp_in;
   logic [zsif_pkg::K_W-1:0]           k_ff, k_in;
   logic [zsif_pkg::TAP_IDX_W-1:0]     j_ff, j_in;

   logic                               req_accept;
   logic                               k_last;
   logic                               j_last;
   logic [zsif_pkg::INTERP_W-1:0]      csr_factor;
   logic [zsif_pkg::TAP_CNT_W-1:0]     csr_taps;
   logic [zsif_pkg::TAP_CNT_W-1:0]     raddr_wide;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   assign k_last = (k_ff == zsif_pkg::K_W'(factor_ff - zsif_pkg::INTERP_W'(1)));
   assign j_last = (j_ff == zsif_pkg::TAP_IDX_W'(taps_ff - zsif_pkg::TAP_CNT_W'(1)));

   // Register values are clamped into range as they are written
   always_comb begin
      csr_factor = zsif_pkg::INTERP_W'(csr_data);
      if (csr_factor == '0) begin
         csr_factor = zsif_pkg::INTERP_W'(1);
      end else if (csr_factor > zsif_pkg::INTERP_W'(zsif_pkg::MAX_INTERP)) begin
         csr_factor = zsif_pkg::INTERP_W'(zsif_pkg::MAX_INTERP);
      end
      csr_taps = zsif_pkg::TAP_CNT_W'(csr_data);
      if (csr_taps < zsif_pkg::TAP_CNT_W'(2)) begin
         csr_taps = zsif_pkg::TAP_CNT_W'(2);
      end else if (csr_taps > zsif_pkg::TAP_CNT_W'(zsif_pkg::MAX_TAPS)) begin
         csr_taps = zsif_pkg::TAP_CNT_W'(zsif_pkg::MAX_TAPS);
      end
   end

   always_comb begin
      factor_in = factor_ff;
      taps_in   = taps_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            zsif_pkg::REG_INTERP_FACTOR: factor_in = csr_factor;
            zsif_pkg::REG_TAP_COUNT:     taps_in   = csr_taps;
            default: ;
         endcase
      end
   end

   // History read address: newest write minus (taps-1-j), modulo depth
   assign raddr_wide = zsif_pkg::TAP_CNT_W'(wp_ff) + zsif_pkg::TAP_CNT_W'(j_ff)
                       + zsif_pkg::TAP_CNT_W'(1) - taps_ff;

   // Sequencing
   always_comb begin
      state_in = state_ff;
      wp_in    = wp_ff;
      k_in     = k_ff;
      j_in     = j_ff;

      cmd            = '0;
      cmd.capture    = req_accept && (req_command == zsif_pkg::CMD_FILTER);
      cmd.coeff_we   = req_accept && (req_command == zsif_pkg::CMD_LOAD);
      cmd.hist_waddr = wp_ff;
      cmd.stuff_zero = (k_ff != '0);
      cmd.rd_tap     = j_ff;
      cmd.hist_raddr = raddr_wide[zsif_pkg::TAP_IDX_W-1:0];
      cmd.emit_last  = k_last;

      case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) begin
               k_in     = '0;
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.hist_we   = 1'b1;
            cmd.acc_clear = 1'b1;
            j_in          = '0;
            state_in      = ST_MAC;
         end
         ST_MAC: begin
            cmd.rd_issue = 1'b1;
            j_in         = j_ff + zsif_pkg::TAP_IDX_W'(1);
            if (j_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!sts.pipe_busy && sts.out_free) begin
               cmd.emit = 1'b1;
               wp_in    = wp_ff + zsif_pkg::TAP_IDX_W'(1);
               if (k_last) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + zsif_pkg::K_W'(1);
                  state_in = ST_WRITE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         factor_ff <= zsif_pkg::INTERP_W'(1);
         taps_ff   <= zsif_pkg::TAP_CNT_W'(zsif_pkg::MAX_TAPS);
         wp_ff     <= '0;
         k_ff      <= '0;
         j_ff      <= '0;
      end else begin
         state_ff  <= state_in;
         factor_ff <= factor_in;
         taps_ff   <= taps_in;
         wp_ff     <= wp_in;
         k_ff      <= k_in;
         j_ff      <= j_in;
      end
   end

   // A history write is followed at once by the read of tap 0
   assert property (@(posedge clock) disable iff (reset)
      cmd.hist_we |=> (cmd.rd_issue && (cmd.rd_tap == '0)))
      else $error("tap sweep does not follow history write");

   // The sample goes in unstuffed on the first write
   assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (cmd.hist_we && !cmd.stuff_zero))
      else $error("captured sample not written first");

   // Every output but the last is followed by a stuffed zero write
   assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && !cmd.emit_last) |=> (cmd.hist_we && cmd.stuff_zero))
      else $error("missing zero stuffing write");

   // New requests only once the MAC pipeline has emptied
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !sts.pipe_busy)
      else $error("request taken with MAC pipeline busy");

endmodule

[hdl/zsif_datapath.sv]
`timescale 1ns / 1ps

// Stores, multiply-accumulate pipeline, rounding and output register
module zsif_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  zsif_pkg::zsif_cmd_type                cmd,
   output zsif_pkg::zsif_sts_type                sts,
   input  logic signed [zsif_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic [zsif_pkg::TIME_W-1:0]           req_sample_time,
   input  logic [zsif_pkg::COEFF_IDX_W-1:0]      req_coeff_index,
   input  logic signed [zsif_pkg::COEFF_W-1:0]   req_coeff_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [zsif_pkg::SAMPLE_W-1:0]  rsp_filtered,
   output logic [zsif_pkg::TIME_W-1:0]           rsp_out_time,
   output logic                                  rsp_last,
   output logic                                  rsp_saturated
);

   logic signed [zsif_pkg::SAMPLE_W-1:0]   sample_ff;
   logic [zsif_pkg::TIME_W-1:0]            time_ff;

   logic [zsif_pkg::MAX_TAPS-1:0]          hist_valid_ff, hist_valid_in;
   logic [zsif_pkg::MAX_TAPS-1:0]          coeff_valid_ff, coeff_valid_in;
   logic                                   coeff_in_range;
   logic [zsif_pkg::SAMPLE_W-1:0]          hist_wdata;
   logic [zsif_pkg::SAMPLE_W-1:0]          hist_q;
   logic [zsif_pkg::COEFF_W-1:0]           coeff_q;
   logic                                   hist_vq_ff;
   logic                                   coeff_vq_ff;

   logic                                   s1_ff, s2_ff;
   logic signed [zsif_pkg::SAMPLE_W-1:0]   hist_val;
   logic signed [zsif_pkg::COEFF_W-1:0]    coeff_val;
   logic signed [zsif_pkg::PROD_W-1:0]     prod_ff;
   logic signed [zsif_pkg::ACC_W-1:0]      acc_ff;

   logic signed [zsif_pkg::ACC_W-1:0]      rnd;
   logic [zsif_pkg::Y_W-1:0]               y;
   logic                                   fits;
   logic signed [zsif_pkg::SAMPLE_W-1:0]   y_sat;

   logic                                   rsp_valid_ff;
   logic signed [zsif_pkg::SAMPLE_W-1:0]   filtered_ff;
   logic [zsif_pkg::TIME_W-1:0]            out_time_ff;
   logic                                   last_ff;
   logic                                   sat_ff;

   // Request payload held for the whole sample
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= req_sample;
         time_ff   <= req_sample_time;
      end
   end

   assign coeff_in_range = (zsif_pkg::TAP_CNT_W'(req_coeff_index)
                            < zsif_pkg::TAP_CNT_W'(zsif_pkg::MAX_TAPS));
   assign hist_wdata     = cmd.stuff_zero ? '0 : sample_ff;

   zsif_ram #(
      .WIDTH (zsif_pkg::SAMPLE_W),
      .DEPTH (zsif_pkg::MAX_TAPS)
   ) u_hist_ram (
      .clock (clock),
      .we    (cmd.hist_we),
      .waddr (cmd.hist_waddr),
      .wdata (hist_wdata),
      .raddr (cmd.hist_raddr),
      .rdata (hist_q)
   );

   zsif_ram #(
      .WIDTH (zsif_pkg::COEFF_W),
      .DEPTH (zsif_pkg::MAX_TAPS)
   ) u_coeff_ram (
      .clock (clock),
      .we    (cmd.coeff_we && coeff_in_range),
      .waddr (zsif_pkg::TAP_IDX_W'(req_coeff_index)),
      .wdata (req_coeff_value),
      .raddr (cmd.rd_tap),
      .rdata (coeff_q)
   );

   // Entries never written read as zero
   always_comb begin
      hist_valid_in  = hist_valid_ff;
      coeff_valid_in = coeff_valid_ff;
      if (cmd.hist_we) begin
         hist_valid_in[cmd.hist_waddr] = 1'b1;
      end
      if (cmd.coeff_we && coeff_in_range) begin
         coeff_valid_in[zsif_pkg::TAP_IDX_W'(req_coeff_index)] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_valid_ff  <= '0;
         coeff_valid_ff <= '0;
      end else begin
         hist_valid_ff  <= hist_valid_in;
         coeff_valid_ff <= coeff_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hist_vq_ff  <= hist_valid_ff[cmd.hist_raddr];
      coeff_vq_ff <= coeff_valid_ff[cmd.rd_tap];
   end

   assign hist_val  = hist_vq_ff  ? $signed(hist_q)  : '0;
   assign coeff_val = coeff_vq_ff ? $signed(coeff_q) : '0;

   // Stage flags of the MAC pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0;
         s2_ff <= 1'b0;
      end else begin
         s1_ff <= cmd.rd_issue;
         s2_ff <= s1_ff;
      end
   end

   // Multiply, then accumulate
   always_ff @(posedge clock) begin
      prod_ff <= hist_val * coeff_val;
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_clear) begin
         acc_ff <= '0;
      end else if (s2_ff) begin
         acc_ff <= acc_ff
                   + {{(zsif_pkg::ACC_W-zsif_pkg::PROD_W){prod_ff[zsif_pkg::PROD_W-1]}}, prod_ff};
      end
   end

   // Round half up, drop the fraction, clip to 16 bits
   assign rnd   = acc_ff + zsif_pkg::ROUND_BIAS;
   assign y     = rnd[zsif_pkg::ACC_W-1:zsif_pkg::FRAC_BITS];
   assign fits  = (y[zsif_pkg::Y_W-1:zsif_pkg::SAMPLE_W-1] == '0)
                  || (y[zsif_pkg::Y_W-1:zsif_pkg::SAMPLE_W-1] == '1);
   assign y_sat = fits ? $signed(y[zsif_pkg::SAMPLE_W-1:0])
                : (y[zsif_pkg::Y_W-1] ? zsif_pkg::OUT_MIN : zsif_pkg::OUT_MAX);

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         filtered_ff <= y_sat;
         out_time_ff <= time_ff;
         last_ff     <= cmd.emit_last;
         sat_ff      <= !fits;
      end
   end

   assign sts.pipe_busy = s1_ff || s2_ff;
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_filtered  = filtered_ff;
   assign rsp_out_time  = out_time_ff;
   assign rsp_last      = last_ff;
   assign rsp_saturated = sat_ff;

   // A result only appears after the controller loads one
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.emit))
      else $error("result raised without emit");

   // A clipped result sits at one of the rails
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && sat_ff) |-> ((filtered_ff == zsif_pkg::OUT_MAX)
                                    || (filtered_ff == zsif_pkg::OUT_MIN)))
      else $error("saturated result not at a rail");

endmodule
